@@ rtl/http_request_line_parser_assert.svh @@
// assertion macros used by the rtl command queue
// each macro samples on clk and is disabled while rst_n is low
`ifndef HTTP_REQUEST_LINE_PARSER_ASSERT_SVH
`define HTTP_REQUEST_LINE_PARSER_ASSERT_SVH

// same-cycle implication
`define HRLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HRLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hrlp_pkg.sv @@
`timescale 1ns / 1ps

package hrlp_pkg;

  // special bytes of the request stream
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_PCT = 8'h25;

  // result kind codes
  localparam logic KIND_URI    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // request status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_NOTIMPL = 2'd2
  } status_t;

  // percent decoder phases
  typedef enum logic [1:0] {
    PCT_NONE   = 2'd0,
    PCT_FIRST  = 2'd1,
    PCT_SECOND = 2'd2
  } pct_t;

  // command queue between parser and result side
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // everything one input word produces: an optional uri byte and an optional status
  typedef struct packed {
    logic    uri_vld;
    logic [7:0] uri_byte;
    logic    stat_vld;
    status_t status;
    logic    simple;
  } cmd_t;

  // characters of the only supported method
  function automatic logic [7:0] get_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h47;
      2'd1:    ch = 8'h45;
      default: ch = 8'h54;
    endcase
    return ch;
  endfunction

  // hex digit decode, msb is the valid flag
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

@@ rtl/hrlp_front.sv @@
`timescale 1ns / 1ps

module hrlp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        data_byte,
  input  logic              end_of_input,
  output logic              cmd_push,
  output hrlp_pkg::cmd_t    cmd
);

  // parser state
  logic               phase_r, phase_nxt;
  logic [1:0]         tok_idx_r, tok_idx_nxt;
  logic               in_tok_r, in_tok_nxt;
  logic [1:0]         meth_prog_r, meth_prog_nxt;
  logic               meth_mis_r, meth_mis_nxt;
  hrlp_pkg::pct_t     pct_ph_r, pct_ph_nxt;
  logic [7:0]         pct_val_r, pct_val_nxt;
  logic               pct_stop_r, pct_stop_nxt;
  logic [1:0]         line_len_r, line_len_nxt;
  logic               line_cr_r, line_cr_nxt;

  logic               blank;
  logic               fin;
  logic               is_get;
  logic [4:0]         hd;
  hrlp_pkg::cmd_t     c;

  // next state and produced command for the current word
  always_comb begin
    phase_nxt     = phase_r;
    tok_idx_nxt   = tok_idx_r;
    in_tok_nxt    = in_tok_r;
    meth_prog_nxt = meth_prog_r;
    meth_mis_nxt  = meth_mis_r;
    pct_ph_nxt    = pct_ph_r;
    pct_val_nxt   = pct_val_r;
    pct_stop_nxt  = pct_stop_r;
    line_len_nxt  = line_len_r;
    line_cr_nxt   = line_cr_r;
    c             = '0;
    c.status      = hrlp_pkg::ST_OK;
    hd            = hrlp_pkg::hex_digit(data_byte);
    is_get        = 1'b0;

    blank = (data_byte == hrlp_pkg::CH_LF) &&
            ((line_len_r == 2'd0) || (line_len_r == 2'd1 && line_cr_r));
    fin   = blank || end_of_input;

    if (data_byte == hrlp_pkg::CH_LF) begin
      // non-blank line end: close the first line
      if (!blank) begin
        if (!phase_nxt) begin
          if (in_tok_nxt && tok_idx_nxt == 2'd2 && pct_ph_nxt != hrlp_pkg::PCT_NONE) begin
            c.uri_vld  = 1'b1;
            c.uri_byte = pct_val_nxt;
          end
          pct_ph_nxt   = hrlp_pkg::PCT_NONE;
          pct_val_nxt  = 8'd0;
          pct_stop_nxt = 1'b0;
          in_tok_nxt   = 1'b0;
          phase_nxt    = 1'b1;
        end
        line_len_nxt = 2'd0;
        line_cr_nxt  = 1'b0;
      end
    end else begin
      if (!phase_nxt) begin
        if (data_byte == hrlp_pkg::CH_SP || data_byte == hrlp_pkg::CH_TAB ||
            data_byte == hrlp_pkg::CH_CR) begin
          // separator closes the token
          if (in_tok_nxt && tok_idx_nxt == 2'd2 && pct_ph_nxt != hrlp_pkg::PCT_NONE) begin
            c.uri_vld  = 1'b1;
            c.uri_byte = pct_val_nxt;
          end
          pct_ph_nxt   = hrlp_pkg::PCT_NONE;
          pct_val_nxt  = 8'd0;
          pct_stop_nxt = 1'b0;
          in_tok_nxt   = 1'b0;
        end else begin
          // token byte
          if (!in_tok_nxt) begin
            in_tok_nxt = 1'b1;
            if (tok_idx_nxt != 2'd3) tok_idx_nxt = tok_idx_nxt + 2'd1;
          end
          is_get = (meth_prog_nxt == 2'd3) && !meth_mis_nxt;
          if (tok_idx_nxt == 2'd1) begin
            if (!meth_mis_nxt && meth_prog_nxt != 2'd3 &&
                data_byte == hrlp_pkg::get_char(meth_prog_nxt)) begin
              meth_prog_nxt = meth_prog_nxt + 2'd1;
            end else begin
              meth_mis_nxt = 1'b1;
            end
          end else if (tok_idx_nxt == 2'd2 && is_get) begin
            // uri byte with percent decoding
            if (pct_ph_nxt == hrlp_pkg::PCT_NONE) begin
              if (data_byte == hrlp_pkg::CH_PCT) begin
                pct_ph_nxt   = hrlp_pkg::PCT_FIRST;
                pct_val_nxt  = 8'd0;
                pct_stop_nxt = 1'b0;
              end else begin
                c.uri_vld  = 1'b1;
                c.uri_byte = data_byte;
              end
            end else begin
              if (!pct_stop_nxt && hd[4]) begin
                pct_val_nxt = {pct_val_nxt[3:0], hd[3:0]};
              end else begin
                pct_stop_nxt = 1'b1;
              end
              if (pct_ph_nxt == hrlp_pkg::PCT_SECOND) begin
                c.uri_vld    = 1'b1;
                c.uri_byte   = pct_val_nxt;
                pct_ph_nxt   = hrlp_pkg::PCT_NONE;
                pct_val_nxt  = 8'd0;
                pct_stop_nxt = 1'b0;
              end else begin
                pct_ph_nxt = hrlp_pkg::PCT_SECOND;
              end
            end
          end
        end
      end
      if (line_len_nxt == 2'd0) line_cr_nxt = (data_byte == hrlp_pkg::CH_CR);
      if (line_len_nxt != 2'd3) line_len_nxt = line_len_nxt + 2'd1;
    end

    // end of request: flush any open percent code, give status, clear
    if (fin) begin
      if (in_tok_nxt && tok_idx_nxt == 2'd2 && pct_ph_nxt != hrlp_pkg::PCT_NONE) begin
        c.uri_vld  = 1'b1;
        c.uri_byte = pct_val_nxt;
      end
      is_get     = (meth_prog_nxt == 2'd3) && !meth_mis_nxt;
      c.stat_vld = 1'b1;
      c.status   = hrlp_pkg::ST_BAD;
      if (tok_idx_nxt == 2'd3) begin
        c.status = is_get ? hrlp_pkg::ST_OK : hrlp_pkg::ST_NOTIMPL;
      end else if (tok_idx_nxt == 2'd2 && is_get) begin
        c.status = hrlp_pkg::ST_OK;
        c.simple = 1'b1;
      end
      phase_nxt     = 1'b0;
      tok_idx_nxt   = 2'd0;
      in_tok_nxt    = 1'b0;
      meth_prog_nxt = 2'd0;
      meth_mis_nxt  = 1'b0;
      pct_ph_nxt    = hrlp_pkg::PCT_NONE;
      pct_val_nxt   = 8'd0;
      pct_stop_nxt  = 1'b0;
      line_len_nxt  = 2'd0;
      line_cr_nxt   = 1'b0;
    end
  end

  assign cmd      = c;
  assign cmd_push = acc && (c.uri_vld || c.stat_vld);

  // state update on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      tok_idx_r   <= 2'd0;
      in_tok_r    <= 1'b0;
      meth_prog_r <= 2'd0;
      meth_mis_r  <= 1'b0;
      pct_ph_r    <= hrlp_pkg::PCT_NONE;
      pct_val_r   <= 8'd0;
      pct_stop_r  <= 1'b0;
      line_len_r  <= 2'd0;
      line_cr_r   <= 1'b0;
    end else if (acc) begin
      phase_r     <= phase_nxt;
      tok_idx_r   <= tok_idx_nxt;
      in_tok_r    <= in_tok_nxt;
      meth_prog_r <= meth_prog_nxt;
      meth_mis_r  <= meth_mis_nxt;
      pct_ph_r    <= pct_ph_nxt;
      pct_val_r   <= pct_val_nxt;
      pct_stop_r  <= pct_stop_nxt;
      line_len_r  <= line_len_nxt;
      line_cr_r   <= line_cr_nxt;
    end
  end

endmodule

@@ rtl/hrlp_queue.sv @@
`timescale 1ns / 1ps

`include "http_request_line_parser_assert.svh"

module hrlp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  hrlp_pkg::cmd_t wr_cmd,
  input  logic           rd_en,
  output hrlp_pkg::cmd_t rd_cmd,
  output logic           full,
  output logic           empty
);

  hrlp_pkg::cmd_t              slot_r [hrlp_pkg::QDEPTH];
  logic [hrlp_pkg::QAW-1:0]    wptr_r, rptr_r;
  logic [hrlp_pkg::QAW:0]      cnt_r, cnt_nxt;

  assign full   = (cnt_r == (hrlp_pkg::QAW+1)'(hrlp_pkg::QDEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_cmd = slot_r[rptr_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) cnt_nxt = cnt_r + (hrlp_pkg::QAW+1)'(1);
    else if (rd_en && !wr_en) cnt_nxt = cnt_r - (hrlp_pkg::QAW+1)'(1);
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr_en) wptr_r <= wptr_r + (hrlp_pkg::QAW)'(1);
      if (rd_en) rptr_r <= rptr_r + (hrlp_pkg::QAW)'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) slot_r[wptr_r] <= wr_cmd;
  end

  `HRLP_ASSERT_NOW(a_no_wr_full, wr_en, !full, "command written into full queue")
  `HRLP_ASSERT_NOW(a_no_rd_empty, rd_en, !empty, "command read from empty queue")
  `HRLP_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= (hrlp_pkg::QAW+1)'(hrlp_pkg::QDEPTH), "count too big")
  `HRLP_ASSERT_NEXT(a_cnt_inc, wr_en && !rd_en, cnt_r == $past(cnt_nxt), "count did not grow")

endmodule

@@ rtl/hrlp_back.sv @@
`timescale 1ns / 1ps

module hrlp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  hrlp_pkg::cmd_t head,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic           pop,
  output logic           out_empty,
  output logic           out_kind,
  output logic [7:0]     out_uri_byte,
  output logic [1:0]     out_status,
  output logic           out_simple_request,
  output logic           out_last
);

  logic uri_done_r;
  logic show_uri;
  logic cmd_last;
  logic take;

  // uri byte goes first, then the status if there is one
  assign show_uri = head.uri_vld && !uri_done_r;
  assign cmd_last = show_uri ? !head.stat_vld : 1'b1;
  assign take     = pop && !q_empty;
  assign q_pop    = take && cmd_last;

  assign out_empty          = q_empty;
  assign out_kind           = show_uri ? hrlp_pkg::KIND_URI : hrlp_pkg::KIND_STATUS;
  assign out_uri_byte       = show_uri ? head.uri_byte : 8'd0;
  assign out_status         = show_uri ? 2'd0 : head.status;
  assign out_simple_request = show_uri ? 1'b0 : head.simple;
  assign out_last           = !show_uri;

  // remember that the uri byte of the head command is gone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uri_done_r <= 1'b0;
    end else if (q_pop) begin
      uri_done_r <= 1'b0;
    end else if (take && show_uri) begin
      uri_done_r <= 1'b1;
    end
  end

endmodule

@@ rtl/http_request_line_parser.sv @@
`timescale 1ns / 1ps

// channel  | ports                                              | handshake
// ---------+----------------------------------------------------+-----------------------
// input    | in_data_byte, in_end_of_input                      | in_push / in_full
// result   | out_kind, out_uri_byte, out_status,                | out_pop / out_empty
//          | out_simple_request, out_last                       |
//
// one input word is taken per cycle while the command queue has room
// a word producing results is registered in the command queue before it appears on the result side
// a word yielding a uri byte and a status needs two result pops
// the 4-entry command queue lets the two sides stall independently
// rst_n clears the parser state and empties the queue

module http_request_line_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_input,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_kind,
  output logic [7:0] out_uri_byte,
  output logic [1:0] out_status,
  output logic       out_simple_request,
  output logic       out_last
);

  logic           acc;
  logic           cmd_push;
  hrlp_pkg::cmd_t cmd;
  hrlp_pkg::cmd_t head;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  assign in_full = q_full;
  assign acc     = in_push && !q_full;

  // parser front
  hrlp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .data_byte    (in_data_byte),
    .end_of_input (in_end_of_input),
    .cmd_push     (cmd_push),
    .cmd          (cmd)
  );

  // command queue
  hrlp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_push),
    .wr_cmd (cmd),
    .rd_en  (q_pop),
    .rd_cmd (head),
    .full   (q_full),
    .empty  (q_empty)
  );

  // result back end
  hrlp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .pop                (out_pop),
    .out_empty          (out_empty),
    .out_kind           (out_kind),
    .out_uri_byte       (out_uri_byte),
    .out_status         (out_status),
    .out_simple_request (out_simple_request),
    .out_last           (out_last)
  );

endmodule
